### sv/key_and_pointer_odometer_unit_macros.svh
// assertion macros shared by the odometer checker
`ifndef KEY_AND_POINTER_ODOMETER_UNIT_MACROS_SVH
`define KEY_AND_POINTER_ODOMETER_UNIT_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge
`define KPO_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("odometer check failed");

// next-cycle implication, sampled on the rising clock edge
`define KPO_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("odometer check failed");

`endif

### sv/kpo_pkg.sv
// types, codes and constants of the key and pointer odometer
package kpo_pkg;

   // event types and codes
   localparam logic [15:0] EV_SYNC = 16'd0;
   localparam logic [15:0] EV_KEY  = 16'd1;
   localparam logic [15:0] EV_REL  = 16'd2;
   localparam logic [15:0] CODE_X  = 16'd0;
   localparam logic [15:0] CODE_Y  = 16'd1;
   localparam logic signed [31:0] KEY_PRESS = 32'sd1;

   // saturation bounds of a motion delta
   localparam logic signed [15:0] DELTA_MAX = 16'sh7fff;
   localparam logic signed [15:0] DELTA_MIN = 16'sh8000;

   // reset scale, 25400/106 in Q16.16
   localparam logic [31:0] MPD_RESET = 32'd15703907;

   // square root: 48-bit radicand, one result bit per step
   localparam int RAD_W      = 48;
   localparam int ROOT_W     = 24;
   localparam int REM_W      = 25;
   localparam int ROOT_STEPS = ROOT_W;
   localparam int STEP_W     = $clog2(ROOT_STEPS);
   localparam int PROD_W     = ROOT_W + 32;

   typedef struct packed {
      logic [15:0]        event_type;
      logic [15:0]        event_code;
      logic signed [31:0] event_value;
   } req_type;

   typedef struct packed {
      logic [31:0] press_count;
      logic [47:0] distance_micrometres;
   } rsp_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic apply;
      logic square_x;
      logic square_y;
      logic root_step;
      logic multiply;
      logic accumulate;
      logic load_rsp;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic need_distance;
   } status_type;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_SQX   = 7'b0000010,
      ST_SQY   = 7'b0000100,
      ST_ROOT  = 7'b0001000,
      ST_MUL   = 7'b0010000,
      ST_ACC   = 7'b0100000,
      ST_LOAD  = 7'b1000000
   } state_type;

endpackage

### sv/key_and_pointer_odometer_unit.sv
// Key press and pointer distance odometer. One event beat is taken at a time on req_ and
// every event gives one result beat on rsp_ with the totals after that event. Key, motion,
// ignored and motionless sync events go from accept straight to the result load; a sync
// with a nonzero latched delta squares x and y, runs the square root unit (one root bit
// per cycle), then a scale multiply, an accumulate and the result load. The result sits
// in an output register, so the next event is accepted while the previous result waits.
// The user must write the scale register via csr_write_enable/csr_write_data only while
// the block is idle (not enforced by the block); it resets to 25400/106 in Q16.16.
module key_and_pointer_odometer_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  kpo_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output kpo_pkg::rsp_type rsp_data,
   input  logic             csr_write_enable,
   input  logic [31:0]      csr_write_data
);

   kpo_pkg::cmd_type    cmd;
   kpo_pkg::status_type status;

   // sequencing
   kpo_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic and state
   kpo_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_data         (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .status           (status),
      .rsp_data         (rsp_data)
   );

endmodule

### sv/kpo_datapath.sv
// odometer datapath: totals, deltas, square root unit, scale multiply
module kpo_datapath (
   input  logic                clock,
   input  logic                reset,
   input  kpo_pkg::cmd_type    cmd,
   input  kpo_pkg::req_type    req_data,
   input  logic                csr_write_enable,
   input  logic [31:0]         csr_write_data,
   output kpo_pkg::status_type status,
   output kpo_pkg::rsp_type    rsp_data
);

   logic [31:0]                     press_ff, press_in;
   logic signed [15:0]              dx_ff, dx_in;
   logic signed [15:0]              dy_ff, dy_in;
   logic [63:0]                     dist_ff, dist_in;
   logic [31:0]                     mpd_ff;
   logic [31:0]                     sq_ff;
   logic [kpo_pkg::RAD_W-1:0]       rad_ff;
   logic [kpo_pkg::REM_W-1:0]       rem_ff;
   logic [kpo_pkg::ROOT_W-1:0]      root_ff;
   logic [kpo_pkg::PROD_W-1:0]      prod_ff;
   kpo_pkg::rsp_type                rsp_ff;

   logic [15:0]                     abs_x, abs_y;
   logic signed [15:0]              sat_value;
   logic [16:0]                     value_top;
   logic [31:0]                     sum_sq;
   logic [kpo_pkg::REM_W+1:0]       rem_cat, trial, rem_diff;
   logic                            fits;

   // saturate the incoming delta to 16 bits signed
   always_comb begin
      value_top = req_data.event_value[31:15];
      fits      = (&value_top) || !(|value_top);
      if (fits) begin
         sat_value = req_data.event_value[15:0];
      end else if (req_data.event_value[31]) begin
         sat_value = kpo_pkg::DELTA_MIN;
      end else begin
         sat_value = kpo_pkg::DELTA_MAX;
      end
   end

   // magnitudes of the latched deltas
   assign abs_x = dx_ff[15] ? 16'(-dx_ff) : 16'(dx_ff);
   assign abs_y = dy_ff[15] ? 16'(-dy_ff) : 16'(dy_ff);
   assign sum_sq = sq_ff + {16'd0, abs_y} * {16'd0, abs_y};

   assign status.need_distance = (req_data.event_type == kpo_pkg::EV_SYNC) &&
                                 ((dx_ff != 16'sd0) || (dy_ff != 16'sd0));

   // one root bit per step from the top two radicand bits
   assign rem_cat  = {rem_ff, rad_ff[kpo_pkg::RAD_W-1 -: 2]};
   assign trial    = {1'b0, root_ff, 2'b01};
   assign rem_diff = rem_cat - trial;

   // event application and distance update
   always_comb begin
      press_in = press_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      dist_in  = dist_ff;
      if (cmd.apply) begin
         case (req_data.event_type)
            kpo_pkg::EV_KEY: begin
               if (req_data.event_value == kpo_pkg::KEY_PRESS) begin
                  press_in = press_ff + 32'd1;
               end
            end
            kpo_pkg::EV_REL: begin
               if (req_data.event_code == kpo_pkg::CODE_X) begin
                  dx_in = sat_value;
               end else if (req_data.event_code == kpo_pkg::CODE_Y) begin
                  dy_in = sat_value;
               end
            end
            default: begin
            end
         endcase
      end
      if (cmd.accumulate) begin
         dist_in = dist_ff + {16'd0, prod_ff[kpo_pkg::PROD_W-1:8]};
         dx_in   = 16'sd0;
         dy_in   = 16'sd0;
      end
   end

   // architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         press_ff <= 32'd0;
         dx_ff    <= 16'sd0;
         dy_ff    <= 16'sd0;
         dist_ff  <= 64'd0;
         mpd_ff   <= kpo_pkg::MPD_RESET;
      end else begin
         press_ff <= press_in;
         dx_ff    <= dx_in;
         dy_ff    <= dy_in;
         dist_ff  <= dist_in;
         if (csr_write_enable) begin
            mpd_ff <= csr_write_data;
         end
      end
   end

   // squares, root iterations, scale multiply, result beat
   always_ff @(posedge clock) begin
      if (cmd.square_x) begin
         sq_ff <= {16'd0, abs_x} * {16'd0, abs_x};
      end
      if (cmd.square_y) begin
         rad_ff  <= {sum_sq, 16'd0};
         rem_ff  <= '0;
         root_ff <= '0;
      end
      if (cmd.root_step) begin
         rad_ff <= {rad_ff[kpo_pkg::RAD_W-3:0], 2'b00};
         if (!rem_diff[kpo_pkg::REM_W+1]) begin
            rem_ff  <= rem_diff[kpo_pkg::REM_W-1:0];
            root_ff <= {root_ff[kpo_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_cat[kpo_pkg::REM_W-1:0];
            root_ff <= {root_ff[kpo_pkg::ROOT_W-2:0], 1'b0};
         end
      end
      if (cmd.multiply) begin
         prod_ff <= {32'd0, root_ff} * {24'd0, mpd_ff};
      end
      if (cmd.load_rsp) begin
         rsp_ff.press_count          <= press_ff;
         rsp_ff.distance_micrometres <= dist_ff[63:16];
      end
   end

   assign rsp_data = rsp_ff;

endmodule

### sv/kpo_controller.sv
// odometer controller: sequencing of one event and the result beat
module kpo_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  kpo_pkg::status_type status,
   output kpo_pkg::cmd_type    cmd
);

   kpo_pkg::state_type              state_ff, state_in;
   logic [kpo_pkg::STEP_W-1:0]      step_ff, step_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            accept, slot_free, root_last;

   assign req_ready = (state_ff == kpo_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign root_last = (step_ff == kpo_pkg::STEP_W'(kpo_pkg::ROOT_STEPS - 1));

   // next state and commands
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      unique case (state_ff)
         kpo_pkg::ST_IDLE: begin
            if (accept) begin
               cmd.apply = 1'b1;
               state_in  = status.need_distance ? kpo_pkg::ST_SQX : kpo_pkg::ST_LOAD;
            end
         end
         kpo_pkg::ST_SQX: begin
            cmd.square_x = 1'b1;
            state_in     = kpo_pkg::ST_SQY;
         end
         kpo_pkg::ST_SQY: begin
            cmd.square_y = 1'b1;
            step_in      = '0;
            state_in     = kpo_pkg::ST_ROOT;
         end
         kpo_pkg::ST_ROOT: begin
            cmd.root_step = 1'b1;
            step_in       = step_ff + 1'b1;
            if (root_last) begin
               state_in = kpo_pkg::ST_MUL;
            end
         end
         kpo_pkg::ST_MUL: begin
            cmd.multiply = 1'b1;
            state_in     = kpo_pkg::ST_ACC;
         end
         kpo_pkg::ST_ACC: begin
            cmd.accumulate = 1'b1;
            state_in       = kpo_pkg::ST_LOAD;
         end
         kpo_pkg::ST_LOAD: begin
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = kpo_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kpo_pkg::ST_IDLE;
         end
      endcase
   end

   // output beat valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kpo_pkg::ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### sv/kpo_checker.sv
// port-level checks of the odometer, bound to the top level
`include "key_and_pointer_odometer_unit_macros.svh"

module kpo_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input kpo_pkg::rsp_type rsp_data
);

   // a stalled result beat holds its totals
   `KPO_ASSERT_NEXT(rsp_hold_chk, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // one event in flight: an accepted beat closes the input until its result is loaded
   `KPO_ASSERT_NEXT(one_in_flight_chk, clock, reset, req_valid && req_ready, !req_ready)

   // out of reset the block is empty and open for an event
   `KPO_ASSERT_NEXT(reset_empty_chk, clock, 1'b0, reset, req_ready && !rsp_valid)

endmodule

bind key_and_pointer_odometer_unit kpo_checker u_kpo_checker (.*);
